// File: design/ll1pp_pkg.sv
// ll1pp_pkg: shared types and codes for the predictive parser unit
// item and result payload structs, operation and action codes, table entry layout
// no dependencies
`timescale 1ns / 1ps

package ll1pp_pkg;

	localparam int unsigned SYM_W      = 5;
	localparam int unsigned PROD_SLOTS = 8;
	localparam int unsigned SYMS_W     = SYM_W * PROD_SLOTS;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_TOKEN = 2'd2
	} op_t;

	// action codes of a result item
	typedef enum logic [3:0] {
		ACT_WRITTEN     = 4'd0,
		ACT_STARTED     = 4'd1,
		ACT_MATCH       = 4'd2,
		ACT_EXPAND      = 4'd3,
		ACT_ACCEPT      = 4'd4,
		ACT_NO_ENTRY    = 4'd5,
		ACT_MISMATCH    = 4'd6,
		ACT_OVERFLOW    = 4'd7,
		ACT_EXP_LIMIT   = 4'd8,
		ACT_NOT_RUNNING = 4'd9
	} act_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_SYMBOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CODE     = 2'd1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [2:0]        nonterm_sel;
		logic [3:0]        term_sel;
		logic              entry_valid;
		logic [3:0]        prod_length;
		logic [SYMS_W-1:0] prod_symbols;
	} item_t;

	typedef struct packed {
		logic [3:0] action;
		logic [2:0] expanded_nonterm;
		logic [3:0] token_seen;
		logic [3:0] pushed_length;
		logic [6:0] stack_depth;
		logic       last;
	} result_t;

	// one parse table entry
	typedef struct packed {
		logic              valid;
		logic [3:0]        len;
		logic [SYMS_W-1:0] syms;
	} tbl_entry_t;

	// one stack symbol: flag set means nonterminal
	typedef struct packed {
		logic       is_nt;
		logic [3:0] idx;
	} sym_t;

endpackage

// File: design/ll1_predictive_parser_unit.sv
// ll1_predictive_parser_unit: table-driven LL(1) parser with table and stack in block memories
// depends on ll1pp_pkg (payload structs, operation and action codes)
`timescale 1ns / 1ps

// Usage
//  item channel (item_valid / item_stall / item): table writes, start of a parse, tokens.
//  result channel (result_valid / result_stall / result): one result per action, the final
//  result of an item has last set. cfg channel (cfg_valid / cfg_ready, always ready) writes
//  start_symbol (index 0), end_code (index 1); the user does so only while idle (unenforced).
// Sequencing
//  a write, a start or a token while not parsing answers in the cycle after acceptance.
//  a token runs a sequencer over the stack memory and the table memory, one access a
//  cycle unless a held result stalls it: a match or a final check is a stack read and
//  an evaluate step, an expansion adds a table read and then one push per symbol (one
//  stack write port). A start writes the end marker, then the start symbol; a write
//  is a single table write. The next item is accepted once the sequencer is back in idle.
// Reset
//  clears stack pointer, parse status (idle) and registers (end_code to 15); the table and
//  stack memories are not cleared, a table entry must be written before it is used.
// Stall
//  the result register holds while result_stall is high; the sequencer waits at its
//  next result and item_stall stays high until the pending result can move.
module ll1_predictive_parser_unit #(
	parameter int unsigned NONTERMS        = 8,
	parameter int unsigned TERMINALS       = 16,
	parameter int unsigned PROD_MAX        = 8,
	parameter int unsigned STACK_DEPTH     = 64,
	parameter int unsigned EXPANSION_LIMIT = 63
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  ll1pp_pkg::item_t                     item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output ll1pp_pkg::result_t                   result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ll1pp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ll1pp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned TBL_DEPTH = NONTERMS * TERMINALS;
	localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int unsigned STK_AW    = $clog2(STACK_DEPTH);
	localparam int unsigned SP_W      = $clog2(STACK_DEPTH + 1);
	localparam int unsigned EXP_W     = $clog2(EXPANSION_LIMIT + 1);
	localparam int unsigned ENT_W     = $bits(ll1pp_pkg::tbl_entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START2,
		ST_TOP_RD,
		ST_TOP_EVAL,
		ST_TBL_EVAL,
		ST_PUSH
	} state_t;

	typedef enum logic [1:0] {
		PS_IDLE,
		PS_RUN,
		PS_DONE
	} status_t;

	// memories
	logic [ENT_W-1:0]              tbl_mem [TBL_DEPTH];
	logic [ll1pp_pkg::SYM_W-1:0]   stk_mem [STACK_DEPTH];

	state_t                        state_q, state_d;
	status_t                       status_q, status_d;
	logic [2:0]                    start_sym_q;
	logic [3:0]                    end_code_q;
	logic [SP_W-1:0]               sp_q, sp_d;
	logic [3:0]                    tok_q, tok_d;
	logic [EXP_W-1:0]              exp_q, exp_d;
	logic [3:0]                    nt_q, nt_d;
	logic [STK_AW-1:0]             push_addr_q, push_addr_d;
	logic [3:0]                    push_cnt_q, push_cnt_d;
	logic                          res_valid_q;
	ll1pp_pkg::result_t            res_q;

	logic                          can_emit;
	logic                          accept;
	logic                          emit;
	ll1pp_pkg::result_t            emit_res;

	logic                          tbl_we, tbl_re;
	logic [TBL_AW-1:0]             tbl_waddr, tbl_raddr;
	ll1pp_pkg::tbl_entry_t         tbl_wdata;
	ll1pp_pkg::tbl_entry_t         tbl_rdata_q;
	logic                          stk_we, stk_re;
	logic [STK_AW-1:0]             stk_waddr, stk_raddr;
	ll1pp_pkg::sym_t               stk_wdata;
	ll1pp_pkg::sym_t               stk_rdata_q;

	logic [3:0]                    len_sat;
	logic [3:0]                    plen;
	logic [SP_W:0]                 grow;
	logic [2:0]                    k_idx;

	assign can_emit     = !res_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE) || !can_emit;
	assign accept       = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign len_sat = (32'(item.prod_length) > PROD_MAX) ? 4'(PROD_MAX) : item.prod_length;
	assign plen    = (32'(tbl_rdata_q.len) > PROD_MAX) ? 4'(PROD_MAX) : tbl_rdata_q.len;
	assign grow    = {1'b0, sp_q} - (SP_W+1)'(1) + (SP_W+1)'(plen);
	assign k_idx   = 3'(push_cnt_q - 4'd1);

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		sp_d        = sp_q;
		tok_d       = tok_q;
		exp_d       = exp_q;
		nt_d        = nt_q;
		push_addr_d = push_addr_q;
		push_cnt_d  = push_cnt_q;
		emit        = 1'b0;
		emit_res    = '0;
		tbl_we      = 1'b0;
		tbl_waddr   = '0;
		tbl_wdata   = '0;
		tbl_re      = 1'b0;
		tbl_raddr   = '0;
		stk_we      = 1'b0;
		stk_waddr   = '0;
		stk_wdata   = '0;
		stk_re      = 1'b0;
		stk_raddr   = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.operation)
						ll1pp_pkg::OP_WRITE: begin
							if (32'(item.nonterm_sel) < NONTERMS &&
									32'(item.term_sel) < TERMINALS) begin
								tbl_we    = 1'b1;
								tbl_waddr = TBL_AW'(32'(item.nonterm_sel) * TERMINALS
									+ 32'(item.term_sel));
								tbl_wdata = '{valid: item.entry_valid, len: len_sat,
									syms: item.prod_symbols};
							end
							emit                 = 1'b1;
							emit_res.action      = ll1pp_pkg::ACT_WRITTEN;
							emit_res.stack_depth = 7'(sp_q);
							emit_res.last        = 1'b1;
						end
						ll1pp_pkg::OP_START: begin
							// end marker now, start symbol in the next cycle
							stk_we               = 1'b1;
							stk_waddr            = '0;
							stk_wdata            = '{is_nt: 1'b0, idx: end_code_q};
							sp_d                 = SP_W'(2);
							status_d             = PS_RUN;
							state_d              = ST_START2;
							emit                 = 1'b1;
							emit_res.action      = ll1pp_pkg::ACT_STARTED;
							emit_res.stack_depth = 7'd2;
							emit_res.last        = 1'b1;
						end
						ll1pp_pkg::OP_TOKEN: begin
							if (status_q != PS_RUN) begin
								emit                 = 1'b1;
								emit_res.action      = ll1pp_pkg::ACT_NOT_RUNNING;
								emit_res.token_seen  = item.term_sel;
								emit_res.stack_depth = 7'(sp_q);
								emit_res.last        = 1'b1;
							end else begin
								tok_d   = item.term_sel;
								exp_d   = '0;
								state_d = ST_TOP_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_START2: begin
				stk_we    = 1'b1;
				stk_waddr = STK_AW'(1);
				stk_wdata = '{is_nt: 1'b1, idx: {1'b0, start_sym_q}};
				state_d   = ST_IDLE;
			end
			ST_TOP_RD: begin
				if (sp_q == '0 || 32'(sp_q) > STACK_DEPTH) begin
					if (can_emit) begin
						emit                 = 1'b1;
						emit_res.action      = ll1pp_pkg::ACT_MISMATCH;
						emit_res.token_seen  = tok_q;
						emit_res.stack_depth = 7'(sp_q);
						emit_res.last        = 1'b1;
						status_d             = PS_DONE;
						state_d              = ST_IDLE;
					end
				end else begin
					stk_re    = 1'b1;
					stk_raddr = STK_AW'(sp_q - SP_W'(1));
					state_d   = ST_TOP_EVAL;
				end
			end
			ST_TOP_EVAL: begin
				if (!stk_rdata_q.is_nt) begin
					if (can_emit) begin
						emit                = 1'b1;
						emit_res.token_seen = tok_q;
						emit_res.last       = 1'b1;
						state_d             = ST_IDLE;
						if (stk_rdata_q.idx == end_code_q && tok_q == end_code_q) begin
							emit_res.action      = ll1pp_pkg::ACT_ACCEPT;
							emit_res.stack_depth = 7'(sp_q);
							status_d             = PS_DONE;
						end else if (stk_rdata_q.idx == tok_q) begin
							sp_d                 = sp_q - SP_W'(1);
							emit_res.action      = ll1pp_pkg::ACT_MATCH;
							emit_res.stack_depth = 7'(sp_q - SP_W'(1));
						end else begin
							emit_res.action      = ll1pp_pkg::ACT_MISMATCH;
							emit_res.stack_depth = 7'(sp_q);
							status_d             = PS_DONE;
						end
					end
				end else if (32'(stk_rdata_q.idx) >= NONTERMS || 32'(tok_q) >= TERMINALS) begin
					if (can_emit) begin
						emit                 = 1'b1;
						emit_res.action      = ll1pp_pkg::ACT_NO_ENTRY;
						emit_res.token_seen  = tok_q;
						emit_res.stack_depth = 7'(sp_q);
						emit_res.last        = 1'b1;
						status_d             = PS_DONE;
						state_d              = ST_IDLE;
					end
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = TBL_AW'(32'(stk_rdata_q.idx) * TERMINALS + 32'(tok_q));
					nt_d      = stk_rdata_q.idx;
					state_d   = ST_TBL_EVAL;
				end
			end
			ST_TBL_EVAL: begin
				if (can_emit) begin
					emit                 = 1'b1;
					emit_res.token_seen  = tok_q;
					emit_res.stack_depth = 7'(sp_q);
					emit_res.last        = 1'b1;
					if (!tbl_rdata_q.valid) begin
						emit_res.action = ll1pp_pkg::ACT_NO_ENTRY;
						status_d        = PS_DONE;
						state_d         = ST_IDLE;
					end else if (32'(exp_q) >= EXPANSION_LIMIT) begin
						emit_res.action = ll1pp_pkg::ACT_EXP_LIMIT;
						status_d        = PS_DONE;
						state_d         = ST_IDLE;
					end else if (32'(grow) > STACK_DEPTH) begin
						emit_res.action = ll1pp_pkg::ACT_OVERFLOW;
						status_d        = PS_DONE;
						state_d         = ST_IDLE;
					end else begin
						// depth is reported before the pushes land
						emit_res.action           = ll1pp_pkg::ACT_EXPAND;
						emit_res.expanded_nonterm = 3'(nt_q);
						emit_res.pushed_length    = plen;
						emit_res.stack_depth      = 7'(grow);
						emit_res.last             = 1'b0;
						sp_d                      = SP_W'(grow);
						push_addr_d               = STK_AW'(sp_q - SP_W'(1));
						push_cnt_d                = plen;
						exp_d                     = exp_q + EXP_W'(1);
						state_d                   = (plen == 4'd0) ? ST_TOP_RD : ST_PUSH;
					end
				end
			end
			ST_PUSH: begin
				// production goes on in reverse, last symbol lowest
				stk_we      = 1'b1;
				stk_waddr   = push_addr_q;
				stk_wdata   = tbl_rdata_q.syms[k_idx * ll1pp_pkg::SYM_W +: ll1pp_pkg::SYM_W];
				push_addr_d = push_addr_q + STK_AW'(1);
				push_cnt_d  = push_cnt_q - 4'd1;
				if (push_cnt_q == 4'd1) begin
					state_d = ST_TOP_RD;
				end
			end
		endcase
	end

	// sequencer, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			status_q    <= PS_IDLE;
			start_sym_q <= 3'd0;
			end_code_q  <= 4'd15;
			sp_q        <= '0;
			tok_q       <= '0;
			exp_q       <= '0;
			nt_q        <= '0;
			push_addr_q <= '0;
			push_cnt_q  <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q     <= state_d;
			status_q    <= status_d;
			sp_q        <= sp_d;
			tok_q       <= tok_d;
			exp_q       <= exp_d;
			nt_q        <= nt_d;
			push_addr_q <= push_addr_d;
			push_cnt_q  <= push_cnt_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ll1pp_pkg::CFG_START_SYMBOL) begin
					start_sym_q <= cfg_data[2:0];
				end else if (cfg_index == ll1pp_pkg::CFG_END_CODE) begin
					end_code_q <= cfg_data;
				end
			end
			if (emit) begin
				res_valid_q <= 1'b1;
				res_q       <= emit_res;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// table memory; the sequencer never reads and writes it in the same cycle
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rdata_q <= tbl_mem[tbl_raddr];
		end
	end

	// stack memory; reads are issued only after all pushes have landed
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[stk_raddr];
		end
	end

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= STACK_DEPTH)
		else $error("stack pointer beyond stack depth");

	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(exp_q) <= EXPANSION_LIMIT)
		else $error("expansion count beyond limit");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> push_cnt_q != 4'd0)
		else $error("push burst with nothing left to push");

	a_expand_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.last |-> state_q != ST_IDLE)
		else $error("sequencer idle while an item still owes results");
`endif

endmodule
